// ----- sv/sia_pkg.sv -----
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types and constants for the script integer ALU.
// ----------------------------------------------------------------------------
package sia_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [4:0] {
        OP_COMMA = 5'd0,
        OP_ADD   = 5'd1,
        OP_SUB   = 5'd2,
        OP_MUL   = 5'd3,
        OP_DIV   = 5'd4,
        OP_MOD   = 5'd5,
        OP_AND   = 5'd6,
        OP_OR    = 5'd7,
        OP_XOR   = 5'd8,
        OP_SHL   = 5'd9,
        OP_SAR   = 5'd10,
        OP_SHR   = 5'd11,
        OP_EQ    = 5'd12,
        OP_NE    = 5'd13,
        OP_LE    = 5'd14,
        OP_LT    = 5'd15,
        OP_GE    = 5'd16,
        OP_GT    = 5'd17,
        OP_LAND  = 5'd18,
        OP_LOR   = 5'd19,
        OP_PLUS  = 5'd20,
        OP_NEG   = 5'd21,
        OP_NOT   = 5'd22
    } t_opcode;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNDEF = 2'd1,
        ERR_SHIFT = 2'd2,
        ERR_MODZ  = 2'd3
    } t_error;

endpackage

// ----- sv/script_integer_alu.sv -----
// ----------------------------------------------------------------------------
// script_integer_alu
// Pipelined signed integer ALU for a script interpreter.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  input     i_valid / o_stall   i_opcode, i_assign_form, i_lhs, i_rhs
//  output    o_valid / i_stall   o_result, o_write_back, o_error
//
// One beat enters per cycle while o_stall is low; every result passes through the
// input register, the operand stage, one divider step per result bit and the
// output register. The divider's bit-per-stage chain sets the latency.
// Reset clears only the valid bits. A stall at the output holds the output
// register; stages upstream keep moving until they meet a full stage.
// ----------------------------------------------------------------------------
module script_integer_alu #(
    parameter int DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [4:0]            i_opcode,
    input  logic                  i_assign_form,
    input  logic [DATA_WIDTH-1:0] i_lhs,
    input  logic [DATA_WIDTH-1:0] i_rhs,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DATA_WIDTH-1:0] o_result,
    output logic                  o_write_back,
    output logic [1:0]            o_error
);

    localparam int W  = DATA_WIDTH;
    localparam int H  = (W + 1) / 2;
    localparam int L  = W - H;
    localparam int SB = 5 + 1 + 2 + W + W + 2 * L + 3;

    // Input register.
    logic         r_a_valid;
    logic [4:0]   r_a_op;
    logic         r_a_asg;
    logic [W-1:0] r_a_lhs;
    logic [W-1:0] r_a_rhs;
    logic         a_ready;
    logic         dec_ready;

    assign a_ready = !r_a_valid || dec_ready;
    assign o_stall = !a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_op  <= i_opcode;
            r_a_asg <= i_assign_form;
            r_a_lhs <= i_lhs;
            r_a_rhs <= i_rhs;
        end
    end

    // Operand stage.
    logic         d_valid;
    logic [4:0]   d_op;
    logic         d_wb;
    logic [1:0]   d_err;
    logic [W-1:0] d_simple;
    logic [W-1:0] d_pp0;
    logic [L-1:0] d_pp1;
    logic [L-1:0] d_pp2;
    logic         d_aneg;
    logic         d_bneg;
    logic         d_bzero;
    logic [W-1:0] d_maga;
    logic [W-1:0] d_magb;

    logic          c_valid [W+1];
    logic          c_ready [W+1];
    logic [W-1:0]  c_rem   [W+1];
    logic [W-1:0]  c_quo   [W+1];
    logic [W-1:0]  c_den   [W+1];
    logic [SB-1:0] c_sb    [W+1];

    sia_decode #(.W(W), .H(H), .L(L)) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_a_valid),
        .i_op     (r_a_op),
        .i_asg    (r_a_asg),
        .i_a      (r_a_lhs),
        .i_b      (r_a_rhs),
        .o_ready  (dec_ready),
        .i_ready  (c_ready[0]),
        .o_valid  (d_valid),
        .o_op     (d_op),
        .o_wb     (d_wb),
        .o_err    (d_err),
        .o_simple (d_simple),
        .o_pp0    (d_pp0),
        .o_pp1    (d_pp1),
        .o_pp2    (d_pp2),
        .o_aneg   (d_aneg),
        .o_bneg   (d_bneg),
        .o_bzero  (d_bzero),
        .o_maga   (d_maga),
        .o_magb   (d_magb)
    );

    assign c_valid[0] = d_valid;
    assign c_rem[0]   = '0;
    assign c_quo[0]   = d_maga;
    assign c_den[0]   = d_magb;
    assign c_sb[0]    = {d_op, d_wb, d_err, d_simple, d_pp0, d_pp1, d_pp2,
                         d_aneg, d_bneg, d_bzero};

    for (genvar k = 0; k < W; k++) begin : g_div
        sia_div_step #(.W(W), .SB(SB)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .i_rem   (c_rem[k]),
            .i_quo   (c_quo[k]),
            .i_den   (c_den[k]),
            .i_sb    (c_sb[k]),
            .o_ready (c_ready[k]),
            .i_ready (c_ready[k+1]),
            .o_valid (c_valid[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_quo   (c_quo[k+1]),
            .o_den   (c_den[k+1]),
            .o_sb    (c_sb[k+1])
        );
    end

    // Result select and output register.
    logic [4:0]   f_op;
    logic         f_wb;
    logic [1:0]   f_err;
    logic [W-1:0] f_simple;
    logic [W-1:0] f_pp0;
    logic [L-1:0] f_pp1;
    logic [L-1:0] f_pp2;
    logic         f_aneg;
    logic         f_bneg;
    logic         f_bzero;
    logic [L-1:0] f_cross;
    logic [W-1:0] f_prod;
    logic [W-1:0] f_quo;
    logic [W-1:0] f_rem;
    logic [W-1:0] n_result;

    assign {f_op, f_wb, f_err, f_simple, f_pp0, f_pp1, f_pp2,
            f_aneg, f_bneg, f_bzero} = c_sb[W];

    assign f_cross = f_pp1 + f_pp2;
    assign f_prod  = f_pp0 + {f_cross, {H{1'b0}}};
    assign f_quo   = (f_aneg ^ f_bneg) ? ('0 - c_quo[W]) : c_quo[W];
    assign f_rem   = f_aneg ? ('0 - c_rem[W]) : c_rem[W];

    always_comb begin
        if (f_err != sia_pkg::ERR_NONE) begin
            n_result = '0;
        end else begin
            case (sia_pkg::t_opcode'(f_op))
                sia_pkg::OP_MUL: n_result = f_prod;
                sia_pkg::OP_DIV: n_result = f_bzero ? '0 : f_quo;
                sia_pkg::OP_MOD: n_result = f_rem;
                default:         n_result = f_simple;
            endcase
        end
    end

    logic         r_o_valid;
    logic [W-1:0] r_o_result;
    logic         r_o_wb;
    logic [1:0]   r_o_err;

    assign c_ready[W] = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (c_ready[W]) begin
            r_o_valid <= c_valid[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready[W] && c_valid[W]) begin
            r_o_result <= n_result;
            r_o_wb     <= f_wb;
            r_o_err    <= f_err;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_result     = r_o_result;
    assign o_write_back = r_o_wb;
    assign o_error      = r_o_err;

    // A beat that reports an error never writes the variable back.
    a_err_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_error != sia_pkg::ERR_NONE) |-> !o_write_back)
        else $error("write-back asserted on an errored beat");

    // Errored beats always carry a zero result.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_error != sia_pkg::ERR_NONE) |-> (o_result == '0))
        else $error("errored beat carries a nonzero result");

    // Backpressure at the input only while the input register is occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_a_valid)
        else $error("input stalled with an empty input register");

    // A held output beat keeps the full pipeline behind it from advancing.
    a_hold_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall && c_valid[W] |-> !c_ready[W-1])
        else $error("last divider stage advanced into a held output");

endmodule

// ----- sv/sia_decode.sv -----
// ----------------------------------------------------------------------------
// sia_decode
// Operand stage: simple operations, error decode, multiplier partial
// products and divider magnitudes, all registered.
// ----------------------------------------------------------------------------
module sia_decode #(
    parameter int W = sia_pkg::DATA_WIDTH_DEF,
    parameter int H = (W + 1) / 2,
    parameter int L = W - H
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [4:0]   i_op,
    input  logic         i_asg,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_ready,
    input  logic         i_ready,
    output logic         o_valid,
    output logic [4:0]   o_op,
    output logic         o_wb,
    output logic [1:0]   o_err,
    output logic [W-1:0] o_simple,
    output logic [W-1:0] o_pp0,
    output logic [L-1:0] o_pp1,
    output logic [L-1:0] o_pp2,
    output logic         o_aneg,
    output logic         o_bneg,
    output logic         o_bzero,
    output logic [W-1:0] o_maga,
    output logic [W-1:0] o_magb
);

    localparam int SW = $clog2(W);

    logic         r_valid;
    logic [4:0]   r_op;
    logic         r_wb;
    logic [1:0]   r_err;
    logic [W-1:0] r_simple;
    logic [W-1:0] r_pp0;
    logic [L-1:0] r_pp1;
    logic [L-1:0] r_pp2;
    logic         r_aneg;
    logic         r_bneg;
    logic         r_bzero;
    logic [W-1:0] r_maga;
    logic [W-1:0] r_magb;

    logic [W-1:0]   n_simple;
    logic [1:0]     n_err;
    logic           aneg;
    logic           bneg;
    logic           bzero;
    logic           big;
    logic [SW-1:0]  sh;
    logic           lt;
    logic           gt;
    logic [2*H-1:0] p0;
    logic [H+L-1:0] p1;
    logic [H+L-1:0] p2;

    assign aneg  = i_a[W-1];
    assign bneg  = i_b[W-1];
    assign bzero = (i_b == '0);
    assign big   = (i_b >= W'(W));
    assign sh    = i_b[SW-1:0];
    assign lt    = ($signed(i_a) < $signed(i_b));
    assign gt    = ($signed(i_b) < $signed(i_a));
    assign p0    = i_a[H-1:0] * i_b[H-1:0];
    assign p1    = i_a[H-1:0] * i_b[W-1:H];
    assign p2    = i_a[W-1:H] * i_b[H-1:0];

    always_comb begin
        n_simple = '0;
        n_err    = sia_pkg::ERR_NONE;
        unique case (sia_pkg::t_opcode'(i_op))
            sia_pkg::OP_COMMA: n_simple = i_b;
            sia_pkg::OP_ADD:   n_simple = i_a + i_b;
            sia_pkg::OP_SUB:   n_simple = i_a - i_b;
            sia_pkg::OP_MUL:   n_simple = '0;
            sia_pkg::OP_DIV:   n_simple = '0;
            sia_pkg::OP_MOD: begin
                if (bzero) n_err = sia_pkg::ERR_MODZ;
            end
            sia_pkg::OP_AND:   n_simple = i_a & i_b;
            sia_pkg::OP_OR:    n_simple = i_a | i_b;
            sia_pkg::OP_XOR:   n_simple = i_a ^ i_b;
            sia_pkg::OP_SHL: begin
                if (bneg) n_err = sia_pkg::ERR_SHIFT;
                else if (!big) n_simple = i_a << sh;
            end
            sia_pkg::OP_SAR: begin
                if (bneg) n_err = sia_pkg::ERR_SHIFT;
                else if (big) n_simple = {W{aneg}};
                else n_simple = W'($signed(i_a) >>> sh);
            end
            sia_pkg::OP_SHR: begin
                if (bneg) n_err = sia_pkg::ERR_SHIFT;
                else if (!big) n_simple = i_a >> sh;
            end
            sia_pkg::OP_EQ:    n_simple = {{(W-1){1'b0}}, i_a == i_b};
            sia_pkg::OP_NE:    n_simple = {{(W-1){1'b0}}, i_a != i_b};
            sia_pkg::OP_LE:    n_simple = {{(W-1){1'b0}}, !gt};
            sia_pkg::OP_LT:    n_simple = {{(W-1){1'b0}}, lt};
            sia_pkg::OP_GE:    n_simple = {{(W-1){1'b0}}, !lt};
            sia_pkg::OP_GT:    n_simple = {{(W-1){1'b0}}, gt};
            sia_pkg::OP_LAND:  n_simple = {{(W-1){1'b0}}, (i_a != '0) && !bzero};
            sia_pkg::OP_LOR:   n_simple = {{(W-1){1'b0}}, (i_a != '0) || !bzero};
            sia_pkg::OP_PLUS:  n_simple = i_a;
            sia_pkg::OP_NEG:   n_simple = '0 - i_a;
            sia_pkg::OP_NOT:   n_simple = ~i_a;
            default:           n_err = sia_pkg::ERR_UNDEF;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op     <= i_op;
            r_wb     <= i_asg && (i_op >= 5'(sia_pkg::OP_ADD)) &&
                        (i_op <= 5'(sia_pkg::OP_SHR)) && (n_err == sia_pkg::ERR_NONE);
            r_err    <= n_err;
            r_simple <= n_simple;
            r_pp0    <= p0[W-1:0];
            r_pp1    <= p1[L-1:0];
            r_pp2    <= p2[L-1:0];
            r_aneg   <= aneg;
            r_bneg   <= bneg;
            r_bzero  <= bzero;
            r_maga   <= aneg ? ('0 - i_a) : i_a;
            r_magb   <= bneg ? ('0 - i_b) : i_b;
        end
    end

    assign o_valid  = r_valid;
    assign o_op     = r_op;
    assign o_wb     = r_wb;
    assign o_err    = r_err;
    assign o_simple = r_simple;
    assign o_pp0    = r_pp0;
    assign o_pp1    = r_pp1;
    assign o_pp2    = r_pp2;
    assign o_aneg   = r_aneg;
    assign o_bneg   = r_bneg;
    assign o_bzero  = r_bzero;
    assign o_maga   = r_maga;
    assign o_magb   = r_magb;

endmodule

// ----- sv/sia_div_step.sv -----
// ----------------------------------------------------------------------------
// sia_div_step
// One restoring division step as a pipeline stage; carries the rest of the
// beat along unchanged.
// ----------------------------------------------------------------------------
module sia_div_step #(
    parameter int W  = sia_pkg::DATA_WIDTH_DEF,
    parameter int SB = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [W-1:0]  i_rem,
    input  logic [W-1:0]  i_quo,
    input  logic [W-1:0]  i_den,
    input  logic [SB-1:0] i_sb,
    output logic          o_ready,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [W-1:0]  o_rem,
    output logic [W-1:0]  o_quo,
    output logic [W-1:0]  o_den,
    output logic [SB-1:0] o_sb
);

    logic          r_valid;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [SB-1:0] r_sb;

    logic [W:0] shifted;
    logic [W:0] diff;
    logic       fits;

    assign shifted = {i_rem, i_quo[W-1]};
    assign diff    = shifted - {1'b0, i_den};
    assign fits    = !diff[W];

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem <= fits ? diff[W-1:0] : shifted[W-1:0];
            r_quo <= {i_quo[W-2:0], fits};
            r_den <= i_den;
            r_sb  <= i_sb;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_den   = r_den;
    assign o_sb    = r_sb;

endmodule
